// ----- rtl/vcd_line_signal_extractor_top_macros.svh -----
// assertion macros shared by the extractor rtl
`ifndef VCD_LINE_SIGNAL_EXTRACTOR_TOP_MACROS_SVH
`define VCD_LINE_SIGNAL_EXTRACTOR_TOP_MACROS_SVH

// clocked check, disabled while reset is asserted
`define VCDSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that a condition never holds
`define VCDSE_ASSERT_NEVER(lbl, cond, msg) \
  `VCDSE_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/vcdse_pkg.sv -----
// types, constants and the digit accumulator shared by the extractor modules
package vcdse_pkg;

  localparam int unsigned TimeW  = 63;
  localparam int unsigned ValueW = 31;
  localparam int unsigned AccW   = TimeW;
  localparam int unsigned SumW   = AccW + 4;

  localparam logic [TimeW-1:0]  TimeMax  = {TimeW{1'b1}};
  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  localparam logic [7:0] CharHash      = 8'h23;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharLf        = 8'h0A;
  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] SignalIdReset = 8'h21;

  // line phase, one-hot
  typedef enum logic [3:0] {
    PhStart  = 4'b0001,
    PhTime   = 4'b0010,
    PhMatch  = 4'b0100,
    PhIgnore = 4'b1000
  } phase_e;

  // one result item
  typedef struct packed {
    logic [TimeW-1:0]  change_time;
    logic [ValueW-1:0] change_value;
  } result_t;

  // acc * 10 + d, clamped at max (acc never above max)
  function automatic logic [AccW-1:0] acc_digit(
    input logic [AccW-1:0] acc,
    input logic [3:0]      d,
    input logic [AccW-1:0] max
  );
    logic [SumW-1:0] sum;
    sum = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{(SumW-4){1'b0}}, d};
    if (sum > {4'b0000, max}) begin
      return max;
    end
    return sum[AccW-1:0];
  endfunction

endpackage

// ----- rtl/vcd_line_signal_extractor_top.sv -----
// top level of the dump line signal extractor
// a matched byte goes through the input register, then the result register, to the output
// throughput: one text byte per cycle while the output is not stalled
// the input register holds one byte; a stalled output result holds it back
// reset (rst_ni low, asynchronous) returns to line start, clears accumulators,
// empties both registers and sets the signal identifier to '!'
module vcd_line_signal_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [62:0] change_time_o,
  output logic [30:0] change_value_o
);

  `include "vcd_line_signal_extractor_top_macros.svh"

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic [7:0]         signal_id_q;
  logic               advance;
  logic               step;
  logic               hit;
  logic               in_accept;
  vcdse_pkg::result_t fsm_result;
  vcdse_pkg::result_t out_result;

  // the held byte moves on when the result register can take a result
  assign advance    = !out_valid_o || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signal_id_q <= vcdse_pkg::SignalIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      signal_id_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= text_byte_i;
    end
  end

  vcdse_line_fsm u_line_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (byte_q),
    .signal_id_i (signal_id_q),
    .hit_o       (hit),
    .result_o    (fsm_result)
  );

  vcdse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (hit),
    .result_i    (fsm_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign change_time_o  = out_result.change_time;
  assign change_value_o = out_result.change_value;

  `VCDSE_ASSERT(a_stall_needs_item, in_stall_o |-> in_valid_q, "stall with empty input register")
  `VCDSE_ASSERT(a_hit_needs_item, hit |-> step, "result without a processed item")

endmodule

// ----- rtl/vcdse_line_fsm.sv -----
// line phase tracking, time and value accumulation and identifier match
module vcdse_line_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        text_byte_i,
  input  logic [7:0]        signal_id_i,
  output logic              hit_o,
  output vcdse_pkg::result_t result_o
);

  `include "vcd_line_signal_extractor_top_macros.svh"

  vcdse_pkg::phase_e              phase_q, phase_d;
  logic [vcdse_pkg::TimeW-1:0]    time_acc_q, time_acc_d;
  logic                           time_stopped_q, time_stopped_d;
  logic [vcdse_pkg::ValueW-1:0]   value_acc_q, value_acc_d;
  logic                           value_stopped_q, value_stopped_d;
  logic                           line_end;
  logic                           is_digit;
  logic                           hit;
  logic [vcdse_pkg::AccW-1:0]     time_next;
  logic [vcdse_pkg::AccW-1:0]     value_next;

  // byte classes
  assign line_end = (text_byte_i == vcdse_pkg::CharLf) || (text_byte_i == vcdse_pkg::CharNul);
  assign is_digit = text_byte_i inside {[8'h30:8'h39]};

  // saturating decimal accumulators
  assign time_next  = vcdse_pkg::acc_digit(time_acc_q, text_byte_i[3:0], vcdse_pkg::TimeMax);
  assign value_next = vcdse_pkg::acc_digit({{(vcdse_pkg::AccW-vcdse_pkg::ValueW){1'b0}},
                                            value_acc_q},
                                           text_byte_i[3:0],
                                           {{(vcdse_pkg::AccW-vcdse_pkg::ValueW){1'b0}},
                                            vcdse_pkg::ValueMax});

  // next state for one byte
  always_comb begin
    phase_d         = phase_q;
    time_acc_d      = time_acc_q;
    time_stopped_d  = time_stopped_q;
    value_acc_d     = value_acc_q;
    value_stopped_d = value_stopped_q;
    hit             = 1'b0;
    if (line_end) begin
      phase_d         = vcdse_pkg::PhStart;
      time_acc_d      = '0;
      time_stopped_d  = 1'b0;
      value_acc_d     = '0;
      value_stopped_d = 1'b0;
    end else begin
      case (phase_q)
        vcdse_pkg::PhStart: begin
          phase_d = (text_byte_i == vcdse_pkg::CharHash) ? vcdse_pkg::PhTime
                                                         : vcdse_pkg::PhIgnore;
        end
        vcdse_pkg::PhTime: begin
          if (text_byte_i == vcdse_pkg::CharSpace) begin
            phase_d         = vcdse_pkg::PhMatch;
            value_acc_d     = '0;
            value_stopped_d = 1'b0;
          end else if (!time_stopped_q) begin
            if (is_digit) begin
              time_acc_d = time_next;
            end else begin
              time_stopped_d = 1'b1;
            end
          end
        end
        vcdse_pkg::PhMatch: begin
          if (text_byte_i == signal_id_i) begin
            hit     = 1'b1;
            phase_d = vcdse_pkg::PhIgnore;
          end else if (text_byte_i == vcdse_pkg::CharSpace) begin
            value_acc_d     = '0;
            value_stopped_d = 1'b0;
          end else if (!value_stopped_q) begin
            if (is_digit) begin
              value_acc_d = value_next[vcdse_pkg::ValueW-1:0];
            end else begin
              value_stopped_d = 1'b1;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // state registers, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= vcdse_pkg::PhStart;
      time_acc_q      <= '0;
      time_stopped_q  <= 1'b0;
      value_acc_q     <= '0;
      value_stopped_q <= 1'b0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      time_acc_q      <= time_acc_d;
      time_stopped_q  <= time_stopped_d;
      value_acc_q     <= value_acc_d;
      value_stopped_q <= value_stopped_d;
    end
  end

  assign hit_o                 = step_i && hit;
  assign result_o.change_time  = time_acc_q;
  assign result_o.change_value = value_acc_q;

  `VCDSE_ASSERT(a_hit_in_match, hit_o |-> (phase_q == vcdse_pkg::PhMatch), "hit outside match phase")
  `VCDSE_ASSERT(a_hit_then_ignore, hit_o |=> (phase_q == vcdse_pkg::PhIgnore), "no ignore after hit")
  `VCDSE_ASSERT(a_line_end_clears, (step_i && line_end) |=> (phase_q == vcdse_pkg::PhStart && time_acc_q == '0 && value_acc_q == '0), "line end did not clear")

endmodule

// ----- rtl/vcdse_out_reg.sv -----
// result register toward the output channel
module vcdse_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  vcdse_pkg::result_t result_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output vcdse_pkg::result_t result_o
);

  `include "vcd_line_signal_extractor_top_macros.svh"

  logic               out_valid_q;
  vcdse_pkg::result_t result_q;

  // valid flag: set on load, dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `VCDSE_ASSERT_NEVER(a_no_overwrite, load_i && out_valid_q && out_stall_i, "held result overwritten")

endmodule
